// ===== rtl/core/hlc_pkg.sv =====
// Package for the hazard level classifier: types, register indexes and constants.
// Used by the channel interfaces, the evaluation stage and the top level.
// It depends on nothing else.
package hlc_pkg;

    localparam int unsigned LEVEL_W        = 16;
    localparam int unsigned LIMITS_W       = 48;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 48;
    localparam int unsigned TIMER_BITS_DEF = 24;

    localparam logic [15:0] COST_IMPASSABLE = 16'hFFFF;
    localparam logic [15:0] STILL_LIMIT    = 16'd45875;
    localparam logic [15:0] PRESSURE_LIMIT = 16'd13107;
    localparam logic [15:0] CONFIRM_EVAC   = 16'd3000;
    localparam logic [15:0] CONFIRM_ALERT  = 16'd5000;
    localparam logic [15:0] CONFIRM_WARN   = 16'd15000;
    localparam logic [15:0] CONFIRM_STBY   = 16'd20000;

    localparam logic [15:0] RST_BASE_COST = 16'd256;
    localparam logic [15:0] RST_WEIGHT    = 16'd256;
    localparam logic [47:0] RST_LIMITS    = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_COST       = 3'd0,
        CFG_WEIGHT_PRESSURE = 3'd1,
        CFG_WEIGHT_FLAME    = 3'd2,
        CFG_WEIGHT_SMOKE    = 3'd3,
        CFG_WEIGHT_HEAT     = 3'd4,
        CFG_ALERT_LIMITS    = 3'd5,
        CFG_WARN_LIMITS     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MOOD_STANDBY  = 2'd0,
        MOOD_WARN     = 2'd1,
        MOOD_ALERT    = 2'd2,
        MOOD_EVACUATE = 2'd3
    } t_mood;

    typedef struct packed {
        logic [15:0] base_cost;
        logic [15:0] weight_pressure;
        logic [15:0] weight_flame;
        logic [15:0] weight_smoke;
        logic [15:0] weight_heat;
        logic [47:0] alert_limits;
        logic [47:0] warn_limits;
    } t_cfg;

    typedef struct packed {
        logic [15:0] pressure_level;
        logic [15:0] flame_level;
        logic [15:0] smoke_level;
        logic [15:0] heat_level;
        logic [15:0] air_level;
        logic [15:0] stillness_level;
        logic        node_alive;
        logic        path_blocked;
        logic [15:0] elapsed_ms;
    } t_sample;

    typedef struct packed {
        logic [15:0] node_cost;
        t_mood       hazard_mood;
        logic        sos_alarm;
        logic        trapped_now;
    } t_result;

    function automatic logic [15:0] confirm_ms(input t_mood mood);
        logic [15:0] ms;
        case (mood)
            MOOD_EVACUATE: ms = CONFIRM_EVAC;
            MOOD_ALERT:    ms = CONFIRM_ALERT;
            MOOD_WARN:     ms = CONFIRM_WARN;
            default:       ms = CONFIRM_STBY;
        endcase
        return ms;
    endfunction

endpackage

// ===== rtl/core/hlc_in_if.sv =====
// Input channel of the hazard level classifier: one sensor sample word per handshake.
// Depends on hlc_pkg for the field widths.
interface hlc_in_if
    import hlc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LEVEL_W-1:0]  pressure_level;
    logic [LEVEL_W-1:0]  flame_level;
    logic [LEVEL_W-1:0]  smoke_level;
    logic [LEVEL_W-1:0]  heat_level;
    logic [LEVEL_W-1:0]  air_level;
    logic [LEVEL_W-1:0]  stillness_level;
    logic                node_alive;
    logic                path_blocked;
    logic [15:0]         elapsed_ms;

    modport source (
        output valid, pressure_level, flame_level, smoke_level, heat_level,
               air_level, stillness_level, node_alive, path_blocked, elapsed_ms,
        input  ready
    );

    modport sink (
        input  valid, pressure_level, flame_level, smoke_level, heat_level,
               air_level, stillness_level, node_alive, path_blocked, elapsed_ms,
        output ready
    );
endinterface

// ===== rtl/core/hlc_out_if.sv =====
// Output channel of the hazard level classifier: one result word per handshake.
// Depends on hlc_pkg for the mood type.
interface hlc_out_if
    import hlc_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [15:0] node_cost;
    t_mood       hazard_mood;
    logic        sos_alarm;
    logic        trapped_now;

    modport source (
        output valid, node_cost, hazard_mood, sos_alarm, trapped_now,
        input  ready
    );

    modport sink (
        input  valid, node_cost, hazard_mood, sos_alarm, trapped_now,
        output ready
    );
endinterface

// ===== rtl/core/hazard_level_classifier_unit.sv =====
// Top level of the hazard level classifier: configuration registers, pipeline and state.
// Depends on hlc_pkg, hlc_in_if, hlc_out_if and hlc_eval.
//
// The block takes one sensor sample word per clock while the output is taken and returns one
// result word per sample, in order. A sample is captured in an input register, evaluated in
// one pass (four 16 by 16 multiplies, a sum, threshold compares and the stillness timer
// update) and captured in a result register once that register is free or being read, so
// a result is presented from the result register and the sustained rate is one word per
// cycle while the output is taken. The stillness timer and the SOS latch advance as a
// sample moves into the result register. Configuration writes take effect on the next
// clock and should be made only while no sample is in flight.
module hazard_level_classifier_unit
    import hlc_pkg::*;
#(
    parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hlc_in_if.sink                i_in,
    hlc_out_if.source             o_out
);

    t_cfg                  r_cfg;
    logic                  r_s1_vld;
    t_sample               r_s1;
    logic                  r_out_vld;
    t_result               r_out;
    logic [TIMER_BITS-1:0] r_timer;
    logic                  r_sos;

    t_result               n_out;
    logic [TIMER_BITS-1:0] n_timer;
    logic                  n_sos;
    logic                  w_advance;
    logic                  w_take_in;

    assign w_advance = !r_out_vld || o_out.ready;
    assign w_take_in = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_cost       <= RST_BASE_COST;
            r_cfg.weight_pressure <= RST_WEIGHT;
            r_cfg.weight_flame    <= RST_WEIGHT;
            r_cfg.weight_smoke    <= RST_WEIGHT;
            r_cfg.weight_heat     <= RST_WEIGHT;
            r_cfg.alert_limits    <= RST_LIMITS;
            r_cfg.warn_limits     <= RST_LIMITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_COST:       r_cfg.base_cost       <= i_cfg_data[15:0];
                CFG_WEIGHT_PRESSURE: r_cfg.weight_pressure <= i_cfg_data[15:0];
                CFG_WEIGHT_FLAME:    r_cfg.weight_flame    <= i_cfg_data[15:0];
                CFG_WEIGHT_SMOKE:    r_cfg.weight_smoke    <= i_cfg_data[15:0];
                CFG_WEIGHT_HEAT:     r_cfg.weight_heat     <= i_cfg_data[15:0];
                CFG_ALERT_LIMITS:    r_cfg.alert_limits    <= i_cfg_data[LIMITS_W-1:0];
                CFG_WARN_LIMITS:     r_cfg.warn_limits     <= i_cfg_data[LIMITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_s1.pressure_level  <= i_in.pressure_level;
            r_s1.flame_level     <= i_in.flame_level;
            r_s1.smoke_level     <= i_in.smoke_level;
            r_s1.heat_level      <= i_in.heat_level;
            r_s1.air_level       <= i_in.air_level;
            r_s1.stillness_level <= i_in.stillness_level;
            r_s1.node_alive      <= i_in.node_alive;
            r_s1.path_blocked    <= i_in.path_blocked;
            r_s1.elapsed_ms      <= i_in.elapsed_ms;
        end
    end

    hlc_eval #(
        .TIMER_BITS (TIMER_BITS)
    ) u_eval (
        .i_sample (r_s1),
        .i_cfg    (r_cfg),
        .i_timer  (r_timer),
        .i_sos    (r_sos),
        .o_result (n_out),
        .o_timer  (n_timer),
        .o_sos    (n_sos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_timer   <= '0;
            r_sos     <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_timer <= n_timer;
                r_sos   <= n_sos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.node_cost   = r_out.node_cost;
    assign o_out.hazard_mood = r_out.hazard_mood;
    assign o_out.sos_alarm   = r_out.sos_alarm;
    assign o_out.trapped_now = r_out.trapped_now;

    a_sos_needs_trapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.sos_alarm |-> r_out.trapped_now)
        else $error("SOS word reported without the trapped condition");

    a_evac_iff_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out.hazard_mood == MOOD_EVACUATE) ==
                       (r_out.node_cost == COST_IMPASSABLE)))
        else $error("Evacuate mood and infinite cost disagree");

    a_sos_after_confirm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sos |-> (r_timer > TIMER_BITS'(CONFIRM_EVAC)))
        else $error("SOS latched before the shortest confirm time");

    a_clear_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && w_advance && !n_out.trapped_now |=> (r_timer == '0) && !r_sos)
        else $error("Timer or SOS not cleared after an untrapped sample");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && w_advance |=> r_out.sos_alarm == r_sos)
        else $error("Reported SOS differs from the latched state");

endmodule

// ===== rtl/core/hlc_eval.sv =====
// Evaluation logic of the hazard level classifier: cost, mood, trapped test and timer update.
// Purely combinational; depends on hlc_pkg.
module hlc_eval
    import hlc_pkg::*;
#(
    parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
    input  t_sample               i_sample,
    input  t_cfg                  i_cfg,
    input  logic [TIMER_BITS-1:0] i_timer,
    input  logic                  i_sos,
    output t_result               o_result,
    output logic [TIMER_BITS-1:0] o_timer,
    output logic                  o_sos
);

    logic [31:0]         w_prod_pressure;
    logic [31:0]         w_prod_flame;
    logic [31:0]         w_prod_smoke;
    logic [31:0]         w_prod_heat;
    logic [33:0]         w_acc;
    logic [18:0]         w_total;
    logic [15:0]         w_cost;
    logic                w_inf;
    t_mood               w_mood;
    logic                w_trapped;
    logic [TIMER_BITS:0] w_timer_sum;
    logic [TIMER_BITS-1:0] w_timer_sat;

    assign w_prod_pressure = 32'(i_cfg.weight_pressure) * 32'(i_sample.pressure_level);
    assign w_prod_flame    = 32'(i_cfg.weight_flame) * 32'(i_sample.flame_level);
    assign w_prod_smoke    = 32'(i_cfg.weight_smoke) * 32'(i_sample.smoke_level);
    assign w_prod_heat     = 32'(i_cfg.weight_heat) * 32'(i_sample.heat_level);

    assign w_acc = 34'(w_prod_pressure) + 34'(w_prod_flame)
                 + 34'(w_prod_smoke) + 34'(w_prod_heat);
    assign w_total = 19'(w_acc[33:16]) + 19'(i_cfg.base_cost);

    always_comb begin
        if (!i_sample.node_alive || i_sample.path_blocked) begin
            w_cost = COST_IMPASSABLE;
        end else if (w_total >= 19'(COST_IMPASSABLE)) begin
            w_cost = COST_IMPASSABLE;
        end else begin
            w_cost = w_total[15:0];
        end
    end

    assign w_inf = (w_cost == COST_IMPASSABLE);

    always_comb begin
        if (w_inf) begin
            w_mood = MOOD_EVACUATE;
        end else if (i_sample.flame_level > i_cfg.alert_limits[15:0] ||
                     i_sample.smoke_level > i_cfg.alert_limits[31:16] ||
                     i_sample.air_level > i_cfg.alert_limits[47:32]) begin
            w_mood = MOOD_ALERT;
        end else if (i_sample.pressure_level > i_cfg.warn_limits[15:0] ||
                     i_sample.smoke_level > i_cfg.warn_limits[31:16] ||
                     i_sample.air_level > i_cfg.warn_limits[47:32]) begin
            w_mood = MOOD_WARN;
        end else begin
            w_mood = MOOD_STANDBY;
        end
    end

    assign w_trapped = (i_sample.stillness_level > STILL_LIMIT) &&
                       (i_sample.pressure_level <= PRESSURE_LIMIT);

    // The elapsed time is no wider than the timer, so the sum overflows at most once.
    assign w_timer_sum = {1'b0, i_timer} + (TIMER_BITS+1)'(i_sample.elapsed_ms);
    assign w_timer_sat = w_timer_sum[TIMER_BITS] ? '1 : w_timer_sum[TIMER_BITS-1:0];

    always_comb begin
        if (w_trapped) begin
            o_timer = w_timer_sat;
            o_sos   = i_sos || (w_timer_sat > TIMER_BITS'(confirm_ms(w_mood)));
        end else begin
            o_timer = '0;
            o_sos   = 1'b0;
        end
    end

    always_comb begin
        o_result.node_cost   = w_cost;
        o_result.hazard_mood = w_mood;
        o_result.sos_alarm   = o_sos;
        o_result.trapped_now = w_trapped;
    end

endmodule
